// File: rtl/nbs_pkg.sv
// nbs_pkg: widths, codes and defaults of the periodic cutoff neighbour search
// used by the channel interfaces and every rtl module of the block
package nbs_pkg;

  localparam int POS_W    = 24;
  localparam int IDX_W    = 10;
  localparam int BLK_W    = 4;
  localparam int MASK_W   = 64;
  localparam int CNT_W    = 7;
  localparam int BOX_W    = 24;
  localparam int CUT_W    = 48;
  localparam int PCNT_W   = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam int DEF_MAX_PARTICLES = 1024;
  localparam int DEF_BLOCK_SIZE    = 64;
  localparam int DEF_COORD_BITS    = 24;

  localparam logic [BOX_W-1:0] BOX_RESET = 24'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_X       = 3'd0,
    REG_BOX_Y       = 3'd1,
    REG_BOX_Z       = 3'd2,
    REG_CUTOFF_SQ   = 3'd3,
    REG_PART_COUNT  = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

endpackage

// File: rtl/nbs_if.sv
// nbs_if: request and response channel interfaces, valid/ready handshake
// depends on nbs_pkg for field widths
interface nbs_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [nbs_pkg::IDX_W-1:0]    particle_index;
  logic [nbs_pkg::POS_W-1:0]    pos_x;
  logic [nbs_pkg::POS_W-1:0]    pos_y;
  logic [nbs_pkg::POS_W-1:0]    pos_z;
  logic [nbs_pkg::BLK_W-1:0]    block_index;

  modport source (output valid, req_type, particle_index, pos_x, pos_y, pos_z,
                  block_index, input ready);
  modport sink   (input valid, req_type, particle_index, pos_x, pos_y, pos_z,
                  block_index, output ready);
endinterface

interface nbs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [nbs_pkg::MASK_W-1:0]   neighbor_mask;
  logic [nbs_pkg::CNT_W-1:0]    neighbor_count;
  logic                         out_of_range;
  logic                         is_query_result;

  modport source (output valid, neighbor_mask, neighbor_count, out_of_range,
                  is_query_result, input ready);
  modport sink   (input valid, neighbor_mask, neighbor_count, out_of_range,
                  is_query_result, output ready);
endinterface

// File: rtl/nbs_pos_mem.sv
// nbs_pos_mem: single-port-write, single-port-read position memory
// registered read, no reset on contents
module nbs_pos_mem #(
  parameter int DEPTH = nbs_pkg::DEF_MAX_PARTICLES,
  parameter int DW    = 3 * nbs_pkg::POS_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/nbs_axis_sq.sv
// nbs_axis_sq: minimum-image difference along one axis, squared
// two register stages (fold, square); depends on nbs_pkg
module nbs_axis_sq #(
  parameter int CW = nbs_pkg::DEF_COORD_BITS
) (
  input  logic                           clk_i,
  input  logic [CW-1:0]                  a_i,
  input  logic [CW-1:0]                  b_i,
  input  logic [nbs_pkg::BOX_W-1:0]      box_i,
  output logic [2*nbs_pkg::BOX_W-1:0]    sq_o
);

  localparam int MW = nbs_pkg::BOX_W;
  localparam int DW = MW + 2;

  logic signed [DW-1:0] diff;
  logic signed [DW-1:0] len;
  logic signed [DW-1:0] fold;
  logic signed [DW-1:0] absv;
  logic [MW-1:0]        mag_d, mag_q;
  logic [2*MW-1:0]      sq_q;

  always_comb begin
    diff = signed'(DW'(a_i)) - signed'(DW'(b_i));
    len  = signed'(DW'(box_i));
    if ((diff <<< 1) > len) begin
      fold = diff - len;
    end else if ((diff <<< 1) < -len) begin
      fold = diff + len;
    end else begin
      fold = diff;
    end
    absv  = fold[DW-1] ? -fold : fold;
    mag_d = absv[MW-1:0];
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    sq_q  <= (2*MW)'(mag_q) * (2*MW)'(mag_q);
  end

  assign sq_o = sq_q;

endmodule

// File: rtl/periodic_cutoff_neighbor_search_core.sv
// periodic_cutoff_neighbor_search_core: top level, sequencer, config registers,
// distance compare and result register; uses nbs_pkg, nbs_if, nbs_pos_mem, nbs_axis_sq
//
// Positions live in one memory with a single read port, one entry read per cycle.
// A load with index and position in range is written at acceptance and is
// acknowledged through the done state and the output register. A query
// reads the centre, then streams its candidates through the memory, one per
// cycle, into a fold / square / sum-and-compare pipeline; its candidates are
// the block entries below the particle count and the memory depth.
// A centre index beyond the memory goes to the done state with an empty mask.
// The next item is taken as soon as a result moves to the output register.
// Entries never loaded since reset read back undefined data.
module periodic_cutoff_neighbor_search_core #(
  parameter int MAX_PARTICLES = nbs_pkg::DEF_MAX_PARTICLES,
  parameter int BLOCK_SIZE    = nbs_pkg::DEF_BLOCK_SIZE,
  parameter int COORD_BITS    = nbs_pkg::DEF_COORD_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nbs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [nbs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  nbs_req_if.sink                          req_i,
  nbs_rsp_if.source                        rsp_o
);

  localparam int CW  = (COORD_BITS < nbs_pkg::POS_W) ? COORD_BITS : nbs_pkg::POS_W;
  localparam int AW  = $clog2(MAX_PARTICLES);
  localparam int IW  = $clog2(BLOCK_SIZE + 1);
  localparam int CAW = nbs_pkg::BLK_W + IW;
  localparam int SQW = 2 * nbs_pkg::BOX_W;
  localparam int SW  = SQW + 2;
  localparam int MW  = nbs_pkg::MASK_W;
  localparam int NW  = nbs_pkg::CNT_W;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CENTRE = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [nbs_pkg::BOX_W-1:0]  box_x_q, box_y_q, box_z_q;
  logic [nbs_pkg::CUT_W-1:0]  cutoff_q;
  logic [nbs_pkg::PCNT_W-1:0] pcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q  <= nbs_pkg::BOX_RESET;
      box_y_q  <= nbs_pkg::BOX_RESET;
      box_z_q  <= nbs_pkg::BOX_RESET;
      cutoff_q <= '0;
      pcount_q <= '0;
    end else if (cfg_we_i) begin
      case (nbs_pkg::cfg_reg_e'(cfg_idx_i))
        nbs_pkg::REG_BOX_X:      box_x_q  <= cfg_data_i[nbs_pkg::BOX_W-1:0];
        nbs_pkg::REG_BOX_Y:      box_y_q  <= cfg_data_i[nbs_pkg::BOX_W-1:0];
        nbs_pkg::REG_BOX_Z:      box_z_q  <= cfg_data_i[nbs_pkg::BOX_W-1:0];
        nbs_pkg::REG_CUTOFF_SQ:  cutoff_q <= cfg_data_i[nbs_pkg::CUT_W-1:0];
        nbs_pkg::REG_PART_COUNT: pcount_q <= cfg_data_i[nbs_pkg::PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input transaction decode
  logic                         req_acc;
  logic                         is_query;
  logic                         ctr_ok;
  logic [CW-1:0]                px_m, py_m, pz_m;
  logic                         bad_pos;
  logic                         mem_we;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign is_query    = (req_i.req_type == nbs_pkg::REQ_QUERY);
  assign ctr_ok      = (32'(req_i.particle_index) < MAX_PARTICLES);
  assign px_m        = req_i.pos_x[CW-1:0];
  assign py_m        = req_i.pos_y[CW-1:0];
  assign pz_m        = req_i.pos_z[CW-1:0];
  assign bad_pos     = (nbs_pkg::BOX_W'(px_m) >= box_x_q) ||
                       (nbs_pkg::BOX_W'(py_m) >= box_y_q) ||
                       (nbs_pkg::BOX_W'(pz_m) >= box_z_q);
  assign mem_we      = req_acc && !is_query && !bad_pos && ctr_ok;

  // query sequencing
  logic [AW-1:0]  ctr_addr_q;
  logic [CAW-1:0] base_q;
  logic [IW-1:0]  cand_i_q;
  logic [CAW-1:0] cand;
  logic           issue_ok;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;

  assign cand     = base_q + CAW'(cand_i_q);
  assign issue_ok = (cand_i_q < IW'(BLOCK_SIZE)) &&
                    (32'(cand) < 32'(pcount_q)) &&
                    (32'(cand) < MAX_PARTICLES);
  assign rd_en    = (state_q == ST_CENTRE) || ((state_q == ST_SCAN) && issue_ok);
  assign rd_addr  = (state_q == ST_CENTRE) ? ctr_addr_q : AW'(cand);

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      ctr_addr_q <= AW'(req_i.particle_index);
      base_q     <= CAW'(req_i.block_index) * CAW'(BLOCK_SIZE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_i_q <= '0;
    end else if (req_acc) begin
      cand_i_q <= '0;
    end else if ((state_q == ST_SCAN) && issue_ok) begin
      cand_i_q <= cand_i_q + IW'(1);
    end
  end

  // position memory
  logic [3*CW-1:0] rd_data;

  nbs_pos_mem #(
    .DEPTH (MAX_PARTICLES),
    .DW    (3 * CW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(req_i.particle_index)),
    .wdata_i ({pz_m, py_m, px_m}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // pipeline tags
  logic          rd_vld_q, rd_ctr_q, s2_vld_q, s3_vld_q, s4_vld_q, s4_hit_q;
  logic [IW-1:0] rd_bit_q, s2_bit_q, s3_bit_q, s4_bit_q;
  logic [CW-1:0] cx_q, cy_q, cz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_ctr_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == ST_SCAN) && issue_ok;
      rd_ctr_q <= (state_q == ST_CENTRE);
      s2_vld_q <= rd_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_bit_q <= cand_i_q;
    s2_bit_q <= rd_bit_q;
    s3_bit_q <= s2_bit_q;
    s4_bit_q <= s3_bit_q;
    if (rd_ctr_q) begin
      cx_q <= rd_data[CW-1:0];
      cy_q <= rd_data[2*CW-1:CW];
      cz_q <= rd_data[3*CW-1:2*CW];
    end
  end

  // distance pipeline
  logic [SQW-1:0] sq_x, sq_y, sq_z;
  logic [SW-1:0]  dist_sum;
  logic           hit;

  nbs_axis_sq #(.CW(CW)) u_ax_x (
    .clk_i (clk_i), .a_i (rd_data[CW-1:0]), .b_i (cx_q), .box_i (box_x_q), .sq_o (sq_x)
  );
  nbs_axis_sq #(.CW(CW)) u_ax_y (
    .clk_i (clk_i), .a_i (rd_data[2*CW-1:CW]), .b_i (cy_q), .box_i (box_y_q), .sq_o (sq_y)
  );
  nbs_axis_sq #(.CW(CW)) u_ax_z (
    .clk_i (clk_i), .a_i (rd_data[3*CW-1:2*CW]), .b_i (cz_q), .box_i (box_z_q),
    .sq_o (sq_z)
  );

  assign dist_sum = SW'(sq_x) + SW'(sq_y) + SW'(sq_z);
  assign hit      = (dist_sum != '0) && (dist_sum <= SW'(cutoff_q));

  always_ff @(posedge clk_i) begin
    s4_hit_q <= hit;
  end

  // accumulation
  logic [MW-1:0] acc_mask_q;
  logic [NW-1:0] acc_cnt_q;
  logic          acc_oor_q;
  logic          acc_qry_q;

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      acc_mask_q <= '0;
      acc_cnt_q  <= '0;
      acc_oor_q  <= !is_query && bad_pos;
      acc_qry_q  <= is_query;
    end else if (s4_vld_q && s4_hit_q) begin
      acc_mask_q <= acc_mask_q | (MW'(1) << s4_bit_q);
      acc_cnt_q  <= acc_cnt_q + NW'(1);
    end
  end

  // output register
  logic          out_vld_q;
  logic          out_load;
  logic [MW-1:0] out_mask_q;
  logic [NW-1:0] out_cnt_q;
  logic          out_oor_q;
  logic          out_qry_q;
  logic          pipe_busy;

  assign out_load  = (state_q == ST_DONE) && (!out_vld_q || rsp_o.ready);
  assign pipe_busy = rd_vld_q || rd_ctr_q || s2_vld_q || s3_vld_q || s4_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mask_q <= acc_mask_q;
      out_cnt_q  <= acc_cnt_q;
      out_oor_q  <= acc_oor_q;
      out_qry_q  <= acc_qry_q;
    end
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.neighbor_mask   = out_mask_q;
  assign rsp_o.neighbor_count  = out_cnt_q;
  assign rsp_o.out_of_range    = out_oor_q;
  assign rsp_o.is_query_result = out_qry_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          state_d = (is_query && ctr_ok) ? ST_CENTRE : ST_DONE;
        end
      end
      ST_CENTRE: state_d = ST_SCAN;
      ST_SCAN: begin
        if (!issue_ok) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
